// ===== rtl/skinned_vertex_bounds_macros.svh =====
// ----------------------------------------------------------------------------
// Skinned vertex bounds assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SKINNED_VERTEX_BOUNDS_MACROS_SVH
`define SKINNED_VERTEX_BOUNDS_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define SVB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("skinned_vertex_bounds: next-cycle check failed");

// The condition must hold on every clock edge.
`define SVB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("skinned_vertex_bounds: invariant check failed");

`endif

// ===== rtl/svb_pkg.sv =====
// ----------------------------------------------------------------------------
// Skinned vertex bounds package
// Item types, opcodes, job classes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package svb_pkg;

    localparam int ENTRIES = 12;

    // Input opcodes.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_VERTEX = 2'd1;
    localparam logic [1:0] OP_LAST   = 2'd2;

    typedef struct packed {
        logic        [1:0]  opcode;
        logic        [5:0]  bone_a;
        logic        [5:0]  bone_b;
        logic        [5:0]  bone_c;
        logic        [5:0]  bone_d;
        logic        [15:0] weight_a;
        logic        [15:0] weight_b;
        logic        [15:0] weight_c;
        logic        [15:0] weight_d;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [31:0] radius;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_VERTEX,
        KIND_LAST
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_BLEND,
        ST_MUL,
        ST_SUM,
        ST_CENTER,
        ST_SQUARE,
        ST_ADD,
        ST_ROOT,
        ST_OUT
    } t_state;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = S32_MAX;
        end else if (v < -66'sd2147483648) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/svb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module svb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/svb_front.sv =====
// ----------------------------------------------------------------------------
// Skinned vertex bounds front end
// Accepts input items, drops those without effect and queues the rest.
// ----------------------------------------------------------------------------
module svb_front #(
    parameter int BONE_COUNT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  svb_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_job_valid,
    output svb_pkg::t_job     o_job,
    input  logic              i_job_ready
);

    svb_pkg::t_job r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          w_keep;
    logic          w_enq;
    logic          w_deq;
    svb_pkg::t_job w_job;

    // Classify the incoming item; unused opcodes and out-of-range loads vanish.
    always_comb begin
        w_job.item = i_item;
        w_job.kind = svb_pkg::KIND_VERTEX;
        w_keep     = 1'b0;
        case (i_item.opcode)
            svb_pkg::OP_LOAD: begin
                w_job.kind = svb_pkg::KIND_LOAD;
                w_keep     = (32'(i_item.bone_a) < BONE_COUNT) &&
                             (32'(i_item.bone_b) < svb_pkg::ENTRIES);
            end
            svb_pkg::OP_VERTEX: begin
                w_job.kind = svb_pkg::KIND_VERTEX;
                w_keep     = 1'b1;
            end
            svb_pkg::OP_LAST: begin
                w_job.kind = svb_pkg::KIND_LAST;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_count == 2'd2);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_slot[r_rd_ptr];
    assign w_enq       = i_push && !o_full && w_keep;
    assign w_deq       = o_job_valid && i_job_ready;

    // Two-entry job queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_deq) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_enq && !w_deq) begin
                r_count <= r_count + 2'd1;
            end else if (!w_enq && w_deq) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_slot[r_wr_ptr] <= w_job;
        end
    end

endmodule

// ===== rtl/svb_back.sv =====
// ----------------------------------------------------------------------------
// Skinned vertex bounds back end
// Bone store, blend and transform datapath, box trackers and radius root.
// ----------------------------------------------------------------------------
module svb_back #(
    parameter int BONE_COUNT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  svb_pkg::t_job      i_job,
    output logic               o_job_ready,
    output logic               o_empty,
    output svb_pkg::t_out_item o_result,
    input  logic               i_pop
);

    localparam int AW = $clog2(BONE_COUNT);
    localparam int NE = svb_pkg::ENTRIES;

    svb_pkg::t_state    r_state, n_state;
    logic [4:0]         r_cnt, n_cnt;
    svb_pkg::t_in_item  r_item;
    logic               r_last;
    logic               r_rd_ok, n_rd_ok;
    logic [15:0]        r_rd_w, n_rd_w;
    logic signed [49:0] r_acc [NE];
    logic signed [31:0] r_m [NE];
    logic signed [63:0] r_prod [9];
    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic signed [31:0] r_center [3];
    logic [31:0]        r_dist [3];
    logic [63:0]        r_sq [3];
    logic [63:0]        r_s, r_r, r_bit;
    svb_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic               w_take;
    logic [5:0]         w_bone_sel;
    logic [15:0]        w_weight_sel;
    logic [AW-1:0]      w_raddr;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_rdata [NE];
    logic [NE-1:0]      w_we;
    logic signed [49:0] w_mac [NE];
    logic signed [31:0] w_blend [NE];
    logic signed [31:0] w_pos [3];
    logic signed [65:0] w_tsum [3];
    logic signed [31:0] w_tval [3];
    logic signed [32:0] w_csum [3];
    logic signed [32:0] w_dwide [3];
    logic signed [31:0] w_cval [3];
    logic [63:0]        w_trial;
    logic [63:0]        w_root;
    logic [31:0]        w_radius;
    logic               w_emit;

    assign o_job_ready = (r_state == svb_pkg::ST_IDLE);
    assign w_take      = i_job_valid && o_job_ready;
    assign w_waddr     = AW'(i_job.item.bone_a);
    assign w_pos[0]    = r_item.pos_x;
    assign w_pos[1]    = r_item.pos_y;
    assign w_pos[2]    = r_item.pos_z;

    // One bank per matrix entry, so a bone's whole matrix is read at once.
    for (genvar e = 0; e < NE; e++) begin : g_bank
        assign w_we[e] = w_take && (i_job.kind == svb_pkg::KIND_LOAD) &&
                         (32'(i_job.item.bone_b) == e);
        svb_ram #(
            .WIDTH (32),
            .DEPTH (BONE_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[e]),
            .i_waddr (w_waddr),
            .i_wdata (i_job.item.pos_x),
            .i_raddr (w_raddr),
            .o_rdata (w_rdata[e])
        );
    end

    // Bone and weight for the read issued this cycle.
    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_bone_sel   = r_item.bone_a;
                w_weight_sel = r_item.weight_a;
            end
            2'd1: begin
                w_bone_sel   = r_item.bone_b;
                w_weight_sel = r_item.weight_b;
            end
            2'd2: begin
                w_bone_sel   = r_item.bone_c;
                w_weight_sel = r_item.weight_c;
            end
            default: begin
                w_bone_sel   = r_item.bone_d;
                w_weight_sel = r_item.weight_d;
            end
        endcase
    end

    assign w_raddr = AW'(w_bone_sel);

    // Weighted entries and their rounded, saturated blends.
    always_comb begin
        for (int e = 0; e < NE; e++) begin
            w_mac[e]   = r_rd_ok ?
                         50'($signed({1'b0, r_rd_w}) * $signed(w_rdata[e])) : 50'sd0;
            w_blend[e] = svb_pkg::sat32(66'((r_acc[e] + 50'sd16384) >>> 15));
        end
    end

    // Row sums of the transform, and centre and half extent per axis.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_tsum[r]  = 66'(r_prod[3*r]) + 66'(r_prod[3*r+1]) + 66'(r_prod[3*r+2]) +
                         (66'(r_m[4*r+3]) <<< 16) + 66'sd32768;
            w_tval[r]  = svb_pkg::sat32(w_tsum[r] >>> 16);
            w_csum[r]  = 33'(r_min[r]) + 33'(r_max[r]);
            w_cval[r]  = 32'(w_csum[r] >>> 1);
            w_dwide[r] = 33'(r_max[r]) - 33'(w_cval[r]);
        end
    end

    // Square root step and final rounding.
    assign w_trial  = r_r + r_bit;
    assign w_root   = (r_s > r_r) ? r_r + 64'd1 : r_r;
    assign w_radius = (w_root > 64'hFFFFFFFF) ? 32'hFFFFFFFF : w_root[31:0];
    assign w_emit   = (r_state == svb_pkg::ST_OUT) && !r_out_valid;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rd_ok = 1'b0;
        n_rd_w  = w_weight_sel;
        case (r_state)
            svb_pkg::ST_IDLE: begin
                if (w_take && (i_job.kind != svb_pkg::KIND_LOAD)) begin
                    n_state = svb_pkg::ST_READ;
                    n_cnt   = 5'd0;
                end
            end
            svb_pkg::ST_READ: begin
                n_rd_ok = (32'(w_bone_sel) < BONE_COUNT) && (r_cnt < 5'd4);
                if (r_cnt == 5'd4) begin
                    n_state = svb_pkg::ST_BLEND;
                    n_cnt   = 5'd0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            svb_pkg::ST_BLEND: begin
                n_state = svb_pkg::ST_MUL;
            end
            svb_pkg::ST_MUL: begin
                n_state = svb_pkg::ST_SUM;
            end
            svb_pkg::ST_SUM: begin
                n_state = r_last ? svb_pkg::ST_CENTER : svb_pkg::ST_IDLE;
            end
            svb_pkg::ST_CENTER: begin
                n_state = svb_pkg::ST_SQUARE;
            end
            svb_pkg::ST_SQUARE: begin
                n_state = svb_pkg::ST_ADD;
            end
            svb_pkg::ST_ADD: begin
                n_state = svb_pkg::ST_ROOT;
                n_cnt   = 5'd0;
            end
            svb_pkg::ST_ROOT: begin
                if (r_cnt == 5'd31) begin
                    n_state = svb_pkg::ST_OUT;
                end
                n_cnt = r_cnt + 5'd1;
            end
            svb_pkg::ST_OUT: begin
                if (!r_out_valid) begin
                    n_state = svb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state, trackers and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svb_pkg::ST_IDLE;
            r_cnt       <= 5'd0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                r_min[r] <= svb_pkg::S32_MAX;
                r_max[r] <= svb_pkg::S32_MIN;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd_ok <= n_rd_ok;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == svb_pkg::ST_SUM) begin
                for (int r = 0; r < 3; r++) begin
                    if (w_tval[r] < r_min[r]) begin
                        r_min[r] <= w_tval[r];
                    end
                    if (w_tval[r] > r_max[r]) begin
                        r_max[r] <= w_tval[r];
                    end
                end
            end else if (w_emit) begin
                for (int r = 0; r < 3; r++) begin
                    r_min[r] <= svb_pkg::S32_MAX;
                    r_max[r] <= svb_pkg::S32_MIN;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rd_w <= n_rd_w;
        if (w_take) begin
            r_item <= i_job.item;
            r_last <= (i_job.kind == svb_pkg::KIND_LAST);
        end
        if (r_state == svb_pkg::ST_READ) begin
            for (int e = 0; e < NE; e++) begin
                r_acc[e] <= (r_cnt == 5'd0) ? 50'sd0 : r_acc[e] + w_mac[e];
            end
        end
        if (r_state == svb_pkg::ST_BLEND) begin
            for (int e = 0; e < NE; e++) begin
                r_m[e] <= w_blend[e];
            end
        end
        if (r_state == svb_pkg::ST_MUL) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[3*r+k] <= 64'(r_m[4*r+k]) * 64'(w_pos[k]);
                end
            end
        end
        if (r_state == svb_pkg::ST_CENTER) begin
            for (int r = 0; r < 3; r++) begin
                r_center[r] <= w_cval[r];
                r_dist[r]   <= w_dwide[r][31:0];
            end
        end
        if (r_state == svb_pkg::ST_SQUARE) begin
            for (int r = 0; r < 3; r++) begin
                r_sq[r] <= 64'(r_dist[r]) * 64'(r_dist[r]);
            end
        end
        if (r_state == svb_pkg::ST_ADD) begin
            r_s   <= r_sq[0] + r_sq[1] + r_sq[2];
            r_r   <= 64'd0;
            r_bit <= 64'd1 << 62;
        end
        if (r_state == svb_pkg::ST_ROOT) begin
            if (r_s >= w_trial) begin
                r_s <= r_s - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (w_emit) begin
            r_out.min_x    <= r_min[0];
            r_out.max_x    <= r_max[0];
            r_out.min_y    <= r_min[1];
            r_out.max_y    <= r_max[1];
            r_out.min_z    <= r_min[2];
            r_out.max_z    <= r_max[2];
            r_out.center_x <= r_center[0];
            r_out.center_y <= r_center[1];
            r_out.center_z <= r_center[2];
            r_out.radius   <= w_radius;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/skinned_vertex_bounds.sv =====
// ----------------------------------------------------------------------------
// Skinned vertex bounds
// Blends bone matrices per vertex and reports each frame's box and radius.
// ----------------------------------------------------------------------------
// Sequencing: a load transfer writes one bone store entry from the idle state.
// A vertex issues four bone reads to the twelve-bank bone store, waits for the
// registered read data, then passes through blend, multiply and sum-and-track
// stages. The last vertex of a frame then runs centre, square, add, the
// bit-pair square root unit (32 steps) for the radius and output; the result
// then waits in a single output register until popped. A two-entry queue in
// front lets new items be pushed while the back end works. Bone entries never
// loaded read as undefined.
module skinned_vertex_bounds #(
    parameter int BONE_COUNT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  svb_pkg::t_in_item  i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output svb_pkg::t_out_item o_result
);

    logic          w_job_valid;
    logic          w_job_ready;
    svb_pkg::t_job w_job;

    // Front end: classification and job queue.
    svb_front #(
        .BONE_COUNT (BONE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_ready (w_job_ready)
    );

    // Back end: bone store, arithmetic and result register.
    svb_back #(
        .BONE_COUNT (BONE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_ready (w_job_ready),
        .o_empty     (o_empty),
        .o_result    (o_result),
        .i_pop       (i_pop)
    );

`include "skinned_vertex_bounds_macros.svh"

    // A popped result leaves the single output register empty in the cycle after the pop.
    `SVB_ASSERT_NEXT(a_pop_frees_output, !o_empty && i_pop, o_empty)
    // A full queue stays full while the back end takes nothing.
    `SVB_ASSERT_NEXT(a_full_holds, o_full && !w_job_ready, o_full)
    // A full queue always has a job on offer to the back end.
    `SVB_ASSERT_ALWAYS(a_full_has_job, !o_full || w_job_valid)

endmodule

// ===== verif/skinned_vertex_bounds_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skinned vertex bounds monitor
// Watches both queue ports of the block, keeps its own copy of the bone
// store and the per-frame box trackers, works out each frame's box, centre
// and radius, and compares every popped result against the oldest one.
// ----------------------------------------------------------------------------
module skinned_vertex_bounds_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  svb_pkg::t_in_item  i_item,
    input  logic               o_full,
    input  logic               o_empty,
    input  logic               i_pop,
    input  svb_pkg::t_out_item o_result,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_items_taken,
    output int                 o_boxes_seen
);

    localparam int BONES = 64;

    logic signed [31:0] bone_mem [BONES*svb_pkg::ENTRIES];
    logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    svb_pkg::t_out_item frame_boxes [$];

    string field_names [10] = '{"min_x", "max_x", "min_y", "max_y", "min_z",
                                "max_z", "center_x", "center_y", "center_z",
                                "radius"};

    // Clamp a wide signed value to 32 bits.
    function automatic logic signed [31:0] clamp32(input logic signed [69:0] v);
        if (v > 70'sd2147483647) begin
            return svb_pkg::S32_MAX;
        end else if (v < -70'sd2147483648) begin
            return svb_pkg::S32_MIN;
        end
        return v[31:0];
    endfunction

    // Square root of a 64-bit value, rounded to nearest, saturated to 32 bits.
    function automatic logic [31:0] root_nearest(input longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s > r) r = r + 1;
        return (r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
    endfunction

    // Apply one accepted input transfer to the shadow state.
    task automatic take_item(input svb_pkg::t_in_item it);
        logic [5:0]         bn [4];
        logic [15:0]        wt [4];
        logic signed [31:0] pp [3];
        logic signed [31:0] mat [svb_pkg::ENTRIES];
        logic signed [31:0] v [3];
        logic signed [69:0] acc;
        longint             sum;
        longint             cen [3];
        longint             lo [3];
        longint             hi [3];
        longint             d;
        longint unsigned    sq;
        svb_pkg::t_out_item box;
        bn = '{it.bone_a, it.bone_b, it.bone_c, it.bone_d};
        wt = '{it.weight_a, it.weight_b, it.weight_c, it.weight_d};
        pp = '{it.pos_x, it.pos_y, it.pos_z};
        if (it.opcode == svb_pkg::OP_LOAD) begin
            if (it.bone_a < BONES && it.bone_b < svb_pkg::ENTRIES)
                bone_mem[it.bone_a*svb_pkg::ENTRIES + it.bone_b] = it.pos_x;
            return;
        end
        if (it.opcode != svb_pkg::OP_VERTEX && it.opcode != svb_pkg::OP_LAST) return;
        // Blend the four matrices, rounding half up to Q16.16.
        for (int e = 0; e < svb_pkg::ENTRIES; e++) begin
            sum = 0;
            for (int k = 0; k < 4; k++)
                if (bn[k] < BONES)
                    sum += longint'(wt[k]) *
                           longint'(bone_mem[bn[k]*svb_pkg::ENTRIES + e]);
            mat[e] = clamp32(70'(sum + 16384) >>> 15);
        end
        // Transform the position, with an implied w of one.
        for (int r = 0; r < 3; r++) begin
            acc = (70'(mat[r*4+3]) <<< 16) + 70'sd32768;
            for (int k = 0; k < 3; k++)
                acc += 70'(mat[r*4+k]) * 70'(pp[k]);
            v[r] = clamp32(acc >>> 16);
        end
        if (v[0] < lo_x) lo_x = v[0];
        if (v[0] > hi_x) hi_x = v[0];
        if (v[1] < lo_y) lo_y = v[1];
        if (v[1] > hi_y) hi_y = v[1];
        if (v[2] < lo_z) lo_z = v[2];
        if (v[2] > hi_z) hi_z = v[2];
        if (it.opcode != svb_pkg::OP_LAST) return;
        // Close the frame: centre, radius, then restart the trackers.
        lo = '{lo_x, lo_y, lo_z};
        hi = '{hi_x, hi_y, hi_z};
        sq = 0;
        for (int k = 0; k < 3; k++) begin
            cen[k] = (lo[k] + hi[k]) >>> 1;
            d = hi[k] - cen[k];
            sq += longint'(d * d);
        end
        box.min_x = lo_x;  box.max_x = hi_x;
        box.min_y = lo_y;  box.max_y = hi_y;
        box.min_z = lo_z;  box.max_z = hi_z;
        box.center_x = cen[0][31:0];
        box.center_y = cen[1][31:0];
        box.center_z = cen[2][31:0];
        box.radius = root_nearest(sq);
        frame_boxes = {frame_boxes, box};
        lo_x = svb_pkg::S32_MAX;  hi_x = svb_pkg::S32_MIN;
        lo_y = svb_pkg::S32_MAX;  hi_y = svb_pkg::S32_MIN;
        lo_z = svb_pkg::S32_MAX;  hi_z = svb_pkg::S32_MIN;
    endtask

    // Compare popped results, then apply pushed items, on each edge.
    always @(posedge i_clk) begin
        svb_pkg::t_out_item want;
        logic [319:0] wbits;
        logic [319:0] gbits;
        if (!i_rst_n) begin
            lo_x <= svb_pkg::S32_MAX;  hi_x <= svb_pkg::S32_MIN;
            lo_y <= svb_pkg::S32_MAX;  hi_y <= svb_pkg::S32_MIN;
            lo_z <= svb_pkg::S32_MAX;  hi_z <= svb_pkg::S32_MIN;
            o_fail_count <= 0;
            o_items_taken <= 0;
            o_boxes_seen <= 0;
            o_pending <= 0;
        end else begin
            if (i_pop && !o_empty) begin
                o_boxes_seen <= o_boxes_seen + 1;
                if (frame_boxes.size() == 0) begin
                    $display("%0t: result transfer with nothing expected: %h",
                             $time, o_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = frame_boxes.pop_front();
                    wbits = want;
                    gbits = o_result;
                    if (wbits != gbits) o_fail_count <= o_fail_count + 1;
                    for (int k = 0; k < 10; k++)
                        if (wbits[319-32*k -: 32] != gbits[319-32*k -: 32])
                            $display("%0t: %s mismatch: expected %h, actual %h",
                                     $time, field_names[k],
                                     wbits[319-32*k -: 32], gbits[319-32*k -: 32]);
                end
            end
            if (i_push && !o_full) begin
                o_items_taken <= o_items_taken + 1;
                take_item(i_item);
            end
            o_pending <= frame_boxes.size();
        end
    end

endmodule

// ===== verif/skinned_vertex_bounds_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skinned vertex bounds testbench
// Loads bone matrices, then sends directed and random vertex frames through
// the block under varying idle rates on both sides and a long output hold,
// and reports the verdict from the monitor's failure count.
// ----------------------------------------------------------------------------
module skinned_vertex_bounds_test;

    localparam logic [1:0] OP_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    svb_pkg::t_in_item  i_item;
    logic               o_full;
    logic               o_empty;
    logic               i_pop;
    svb_pkg::t_out_item o_result;
    int                 fail_count;
    int                 pending;
    int                 items_taken;
    int                 boxes_seen;

    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_req;
    int                 hold_left;
    logic               written [64][svb_pkg::ENTRIES];
    int                 real_items;

    skinned_vertex_bounds dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_item),
        .o_full(o_full), .o_empty(o_empty), .i_pop(i_pop), .o_result(o_result)
    );

    skinned_vertex_bounds_monitor u_monitor (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_item),
        .o_full(o_full), .o_empty(o_empty), .i_pop(i_pop), .o_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_items_taken(items_taken), .o_boxes_seen(boxes_seen)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result side: random pops, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_req != 0) begin
            hold_req = 0;
            hold_left = 300;
            i_pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item, with a random gap first, and wait for its transfer.
    task automatic push_item(input svb_pkg::t_in_item it);
        int gap;
        gap = 0;
        while (gap < 10 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full);
        if (it.opcode == svb_pkg::OP_LOAD && it.bone_b < svb_pkg::ENTRIES)
            written[it.bone_a][it.bone_b] = 1'b1;
        if (it.opcode != OP_SPARE &&
            !(it.opcode == svb_pkg::OP_LOAD && it.bone_b >= svb_pkg::ENTRIES))
            real_items++;
    endtask

    function automatic svb_pkg::t_in_item load_item(input int bone, input int entry,
                                                    input logic [31:0] value);
        svb_pkg::t_in_item it;
        logic [191:0]      noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(svb_pkg::t_in_item)-1:0];
        it.opcode = svb_pkg::OP_LOAD;
        it.bone_a = 6'(bone);
        it.bone_b = 6'(entry);
        it.pos_x = value;
        return it;
    endfunction

    function automatic svb_pkg::t_in_item vertex_item(input logic [1:0] op,
            input int b0, input int b1, input int b2, input int b3,
            input int w0, input int w1, input int w2, input int w3,
            input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        svb_pkg::t_in_item it;
        it.opcode = op;
        it.bone_a = 6'(b0);  it.bone_b = 6'(b1);
        it.bone_c = 6'(b2);  it.bone_d = 6'(b3);
        it.weight_a = 16'(w0);  it.weight_b = 16'(w1);
        it.weight_c = 16'(w2);  it.weight_d = 16'(w3);
        it.pos_x = x;  it.pos_y = y;  it.pos_z = z;
        return it;
    endfunction

    // Matrix entries: mostly near unity scale, sometimes anything at all.
    function automatic logic [31:0] rand_entry();
        if ($urandom_range(9) < 2) return $urandom;
        return $signed($urandom_range(262143)) - 131072;
    endfunction

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(9) < 2) return $urandom;
        return $signed($urandom_range(1 << 24)) - (1 << 23);
    endfunction

    function automatic int rand_weight();
        int r;
        r = $urandom_range(9);
        if (r == 0) return $urandom_range(65535);
        if (r == 1) return 32768;
        return $urandom_range(16384);
    endfunction

    // Pick a bone whose twelve entries have all been loaded.
    function automatic int loaded_bone();
        int b;
        int ok;
        do begin
            b = $urandom_range(63);
            ok = 1;
            for (int e = 0; e < svb_pkg::ENTRIES; e++) if (!written[b][e]) ok = 0;
        end while (!ok);
        return b;
    endfunction

    // Random traffic: mostly frames of vertices, some loads and noise.
    task automatic random_phase(input int count);
        int r;
        int stop_at;
        svb_pkg::t_in_item it;
        stop_at = real_items + count;
        while (real_items < stop_at) begin
            r = $urandom_range(99);
            if (r < 12) begin
                it = load_item($urandom_range(63), $urandom_range(11), rand_entry());
            end else if (r < 16) begin
                it = load_item($urandom_range(63), $urandom_range(63, 12), $urandom);
            end else if (r < 18) begin
                it = load_item(0, 0, 0);
                it.opcode = OP_SPARE;
            end else begin
                it = vertex_item(($urandom_range(7) == 0) ? svb_pkg::OP_LAST
                                                          : svb_pkg::OP_VERTEX,
                                 loaded_bone(), loaded_bone(), loaded_bone(),
                                 loaded_bone(), rand_weight(), rand_weight(),
                                 rand_weight(), rand_weight(),
                                 rand_pos(), rand_pos(), rand_pos());
            end
            push_item(it);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_push <= 1'b0;
        i_item <= '0;
        hold_req = 0;
        hold_left = 0;
        real_items = 0;
        send_idle_pct = 32;
        recv_idle_pct = 79;
        for (int b = 0; b < 64; b++)
            for (int e = 0; e < svb_pkg::ENTRIES; e++) written[b][e] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bone 0 is the identity, bone 1 holds the entry extremes.
        for (int e = 0; e < svb_pkg::ENTRIES; e++)
            push_item(load_item(0, e, (e % 5 == 0) ? 32'h00010000 : 32'h0));
        for (int e = 0; e < svb_pkg::ENTRIES; e++)
            push_item(load_item(1, e, e[0] ? 32'h80000000 : 32'h7FFFFFFF));
        for (int b = 2; b < 8; b++)
            for (int e = 0; e < svb_pkg::ENTRIES; e++)
                push_item(load_item(b, e, rand_entry()));

        // Directed frames: extremes of position, weight and entry.
        push_item(vertex_item(svb_pkg::OP_VERTEX, 0, 0, 0, 0, 8192, 8192, 8192, 8192,
                              32'h7FFFFFFF, 32'h80000000, 32'h0));
        push_item(vertex_item(svb_pkg::OP_LAST, 0, 0, 0, 0, 32768, 0, 0, 0,
                              32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
        push_item(vertex_item(svb_pkg::OP_LAST, 1, 1, 1, 1,
                              65535, 65535, 65535, 65535,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        push_item(vertex_item(svb_pkg::OP_VERTEX, 1, 0, 2, 3, 65535, 0, 32768, 1,
                              32'h80000000, 32'h80000000, 32'h80000000));
        push_item(vertex_item(svb_pkg::OP_LAST, 1, 1, 0, 0, 32768, 0, 0, 0,
                              32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        push_item(vertex_item(svb_pkg::OP_LAST, 0, 0, 0, 0, 0, 0, 0, 0,
                              32'h0, 32'h0, 32'h0));
        push_item(load_item(5, 12, 32'h7FFFFFFF));
        push_item(load_item(63, 63, 32'h80000000));
        push_item(vertex_item(OP_SPARE, 63, 63, 63, 63, 65535, 65535, 65535, 65535,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        push_item(vertex_item(svb_pkg::OP_LAST, 7, 6, 5, 4, 12000, 8000, 7000, 5768,
                              32'h00012345, 32'hFFFE0000, 32'h00300000));

        random_phase(430);
        send_idle_pct = 79;
        recv_idle_pct = 32;
        random_phase(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1;
        random_phase(440);
        i_push <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("Sent %0d transfers in, covering loads, vertices and %0d frame results.",
                 items_taken, boxes_seen);
        $display("Idle rates changed over three phases, with one long output hold.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("Timed out with %0d results still expected.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
